### rtl/core/shm_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helper functions of the sliding Hamming best-match block.
// No dependencies; every other file of the block uses this package.
package shm_pkg;

  localparam int PATTERN_MAX = 64;
  localparam int RECORD_MAX  = 2048;

  localparam int LEN_W      = 7;
  localparam int DIST_W     = 7;
  localparam int BASE_W     = 8;
  localparam int COL_W      = 12;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int COUNT_W    = $clog2(RECORD_MAX + 1);
  localparam int OFFSET_W   = $clog2(RECORD_MAX);

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1) + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_BASE  = 2'd2;

  localparam logic [LEN_W-1:0]  PATTERN_LEN_RESET = 7'd1;
  localparam logic [BASE_W-1:0] COLUMN_BASE_RESET = 8'd14;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic                valid;
    logic                cmp;
    logic                first;
    logic                last;
    logic                short_rec;
    logic [LEN_W-1:0]    len;
    logic [OFFSET_W-1:0] offset;
    logic [BASE_W-1:0]   base;
  } token_t;

  typedef struct packed {
    logic              exact_hit;
    logic [COL_W-1:0]  best_column;
    logic [DIST_W-1:0] min_distance;
  } result_t;

  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] l);
    if (l == '0) begin
      return LEN_W'(1);
    end else if (l > LEN_W'(PATTERN_MAX)) begin
      return LEN_W'(PATTERN_MAX);
    end else begin
      return l;
    end
  endfunction

endpackage

### rtl/core/shm_cell.sv
`timescale 1ns / 1ps
// One window cell: holds one signature bit and hands it to its lower neighbor.
// It also registers the mismatch of the incoming bit against its aligned pattern bit.
// Depends on shm_pkg.
module shm_cell (
  input  logic                clk,
  input  logic                rst,
  input  shm_pkg::cell_ctrl_t ctrl,
  input  logic                shift_in,
  input  logic                pat_bit,
  input  logic                mask_bit,
  output logic                win_bit,
  output logic                mismatch
);

  always_ff @(posedge clk) begin
    if (rst) begin
      win_bit <= 1'b0;
    end else if (ctrl.clear) begin
      win_bit <= 1'b0;
    end else if (ctrl.shift) begin
      win_bit <= shift_in;
    end
  end

  always_ff @(posedge clk) begin
    mismatch <= (shift_in ^ pat_bit) & mask_bit;
  end

endmodule

### rtl/core/shm_popcount.sv
`timescale 1ns / 1ps
// Two-stage registered population count of the mismatch vector.
// The window token travels alongside the count. Depends on shm_pkg.
module shm_popcount (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [shm_pkg::PATTERN_MAX-1:0]   mismatch,
  input  shm_pkg::token_t                   tok_in,
  output shm_pkg::token_t                   tok_mid,
  output shm_pkg::token_t                   tok_out,
  output logic [shm_pkg::DIST_W-1:0]        distance
);

  localparam int GROUPS = (shm_pkg::PATTERN_MAX + 7) / 8;
  localparam int PAD_W  = GROUPS * 8;

  logic [PAD_W-1:0] padded;
  logic [3:0]       group_sum_next [GROUPS];
  logic [3:0]       group_sum      [GROUPS];
  logic [shm_pkg::DIST_W-1:0] distance_next;

  assign padded = PAD_W'(mismatch);

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      group_sum_next[g] = '0;
      for (int b = 0; b < 8; b++) begin
        group_sum_next[g] = group_sum_next[g] + 4'(padded[g*8 + b]);
      end
    end
  end

  always_comb begin
    distance_next = '0;
    for (int g = 0; g < GROUPS; g++) begin
      distance_next = distance_next + shm_pkg::DIST_W'(group_sum[g]);
    end
  end

  always_ff @(posedge clk) begin
    group_sum <= group_sum_next;
    distance  <= distance_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_mid <= '0;
      tok_out <= '0;
    end else begin
      tok_mid <= tok_in;
      tok_out <= tok_mid;
    end
  end

endmodule

### rtl/core/shm_fifo.sv
`timescale 1ns / 1ps
// Result queue between the match pipeline and the output stream.
// Depends on shm_pkg.
module shm_fifo (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  input  shm_pkg::result_t                   push_data,
  input  logic                               pop,
  output logic                               out_valid,
  output shm_pkg::result_t                   out_data,
  output logic [shm_pkg::FIFO_CNT_W-1:0]     count
);

  shm_pkg::result_t               mem [shm_pkg::FIFO_DEPTH];
  logic [shm_pkg::FIFO_PTR_W-1:0] wr_ptr;
  logic [shm_pkg::FIFO_PTR_W-1:0] rd_ptr;
  logic                           do_pop;

  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign do_pop    = pop && out_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/core/sliding_hamming_best_match.sv
`timescale 1ns / 1ps
// Sliding Hamming best match, top level: window cell chain, popcount pipeline, result queue.
// Depends on shm_pkg, shm_cell, shm_popcount and shm_fifo.
//
// The block takes one signature bit per cycle while s_tready is high, through a chain of
// PATTERN_MAX window cells that each compare their bit with the aligned pattern bit.
// A window's distance is registered after its cell mismatch and the group sums, and a
// record's result enters the queue as the tlast token leaves the pipeline. Results
// wait in an eight-entry queue; the input stalls only when that queue together with the
// record ends still in the pipeline would reach eight, so a stalled output stops the input.
// No clearing pass follows reset. Configuration writes are taken in every cycle.
module sliding_hamming_best_match (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [7:0]                          s_tdata,   // [0] sig_bit
  input  logic                                s_tlast,   // record_end
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [23:0]                         m_tdata,   // [6:0] min_distance, [18:7] best_column
  output logic                                m_tuser,   // exact_hit
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [shm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [shm_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int PM = shm_pkg::PATTERN_MAX;

  logic [shm_pkg::CFG_DATA_W-1:0] pattern_bits;
  logic [shm_pkg::LEN_W-1:0]      pattern_len;
  logic [shm_pkg::BASE_W-1:0]     column_base;

  logic [shm_pkg::COUNT_W-1:0]    bit_count;
  logic [shm_pkg::COUNT_W-1:0]    count_after;
  logic [shm_pkg::LEN_W-1:0]      len;
  logic [shm_pkg::LEN_W-1:0]      shift_amt;
  logic                           accept;
  logic                           counted;
  logic [PM-1:0]                  pat_al;
  logic [PM-1:0]                  mask_al;
  logic [PM-1:0]                  win;
  logic [PM-1:0]                  mismatch;
  shm_pkg::cell_ctrl_t            cell_ctrl;
  shm_pkg::token_t                tok_next;
  shm_pkg::token_t                tok1;
  shm_pkg::token_t                tok_mid;
  shm_pkg::token_t                tok3;
  logic [shm_pkg::DIST_W-1:0]     distance;

  logic [shm_pkg::DIST_W-1:0]     best_distance;
  logic [shm_pkg::OFFSET_W-1:0]   best_offset;
  logic                           hit_seen;
  logic [shm_pkg::DIST_W-1:0]     best_distance_next;
  logic [shm_pkg::OFFSET_W-1:0]   best_offset_next;
  logic                           hit_seen_next;

  shm_pkg::result_t               result;
  shm_pkg::result_t               head;
  logic [shm_pkg::FIFO_CNT_W-1:0] fifo_count;
  logic [shm_pkg::FIFO_CNT_W-1:0] pending;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bits <= '0;
      pattern_len  <= shm_pkg::PATTERN_LEN_RESET;
      column_base  <= shm_pkg::COLUMN_BASE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        shm_pkg::CFG_PATTERN_BITS: pattern_bits <= cfg_data;
        shm_pkg::CFG_PATTERN_LEN:  pattern_len  <= cfg_data[shm_pkg::LEN_W-1:0];
        shm_pkg::CFG_COLUMN_BASE:  column_base  <= cfg_data[shm_pkg::BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // Input side: record bit counter and window token.
  assign pending = shm_pkg::FIFO_CNT_W'(tok1.valid && tok1.last)
                 + shm_pkg::FIFO_CNT_W'(tok_mid.valid && tok_mid.last)
                 + shm_pkg::FIFO_CNT_W'(tok3.valid && tok3.last);
  assign s_tready = (fifo_count + pending) < shm_pkg::FIFO_CNT_W'(shm_pkg::FIFO_DEPTH);
  assign accept   = s_tvalid && s_tready;

  assign len         = shm_pkg::eff_len(pattern_len);
  assign counted     = bit_count < shm_pkg::COUNT_W'(shm_pkg::RECORD_MAX);
  assign count_after = counted ? bit_count + 1'b1 : bit_count;
  assign shift_amt   = shm_pkg::LEN_W'(PM) - len;
  assign pat_al      = pattern_bits[PM-1:0] << shift_amt;
  assign mask_al     = {PM{1'b1}} << shift_amt;

  assign cell_ctrl.shift = accept && counted;
  assign cell_ctrl.clear = accept && s_tlast;

  always_comb begin
    tok_next.valid     = accept;
    tok_next.cmp       = counted && (count_after >= shm_pkg::COUNT_W'(len));
    tok_next.first     = counted && (bit_count == '0);
    tok_next.last      = s_tlast;
    tok_next.short_rec = count_after < shm_pkg::COUNT_W'(len);
    tok_next.len       = len;
    tok_next.offset    = shm_pkg::OFFSET_W'(count_after - shm_pkg::COUNT_W'(len));
    tok_next.base      = column_base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_count <= '0;
      tok1      <= '0;
    end else begin
      tok1 <= tok_next;
      if (accept) begin
        bit_count <= s_tlast ? '0 : count_after;
      end
    end
  end

  // Window cell chain; the newest bit enters at the top cell.
  for (genvar gi = 0; gi < PM; gi++) begin : g_cell
    logic shift_in;
    if (gi == PM - 1) begin : g_top
      assign shift_in = s_tdata[0];
    end else begin : g_mid
      assign shift_in = win[gi + 1];
    end
    shm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (cell_ctrl),
      .shift_in (shift_in),
      .pat_bit  (pat_al[gi]),
      .mask_bit (mask_al[gi]),
      .win_bit  (win[gi]),
      .mismatch (mismatch[gi])
    );
  end

  shm_popcount u_popcount (
    .clk      (clk),
    .rst      (rst),
    .mismatch (mismatch),
    .tok_in   (tok1),
    .tok_mid  (tok_mid),
    .tok_out  (tok3),
    .distance (distance)
  );

  // Best-window tracking.
  always_comb begin
    best_distance_next = tok3.first ? shm_pkg::DIST_W'(tok3.len) : best_distance;
    best_offset_next   = best_offset;
    hit_seen_next      = hit_seen;
    if (tok3.cmp && !hit_seen) begin
      if (distance == '0) begin
        hit_seen_next      = 1'b1;
        best_distance_next = '0;
        best_offset_next   = tok3.offset;
      end else if (distance <= best_distance_next) begin
        best_distance_next = distance;
        best_offset_next   = tok3.offset;
      end
    end
  end

  always_comb begin
    if (tok3.short_rec) begin
      result.min_distance = shm_pkg::DIST_W'(tok3.len);
      result.best_column  = shm_pkg::COL_W'(tok3.base);
      result.exact_hit    = 1'b0;
    end else begin
      result.min_distance = best_distance_next;
      result.best_column  = shm_pkg::COL_W'(tok3.base) + shm_pkg::COL_W'(best_offset_next);
      result.exact_hit    = hit_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_distance <= shm_pkg::DIST_W'(shm_pkg::PATTERN_LEN_RESET);
      best_offset   <= '0;
      hit_seen      <= 1'b0;
    end else if (tok3.valid) begin
      if (tok3.last) begin
        best_distance <= shm_pkg::DIST_W'(tok3.len);
        best_offset   <= '0;
        hit_seen      <= 1'b0;
      end else begin
        best_distance <= best_distance_next;
        best_offset   <= best_offset_next;
        hit_seen      <= hit_seen_next;
      end
    end
  end

  shm_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (tok3.valid && tok3.last),
    .push_data (result),
    .pop       (m_tready),
    .out_valid (m_tvalid),
    .out_data  (head),
    .count     (fifo_count)
  );

  assign m_tdata = {5'b0, head.best_column, head.min_distance};
  assign m_tuser = head.exact_hit;

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench for sliding_hamming_best_match: streams signature records bit by bit, predicts
// each record's best window and checks every result transaction. Depends on shm_pkg and the RTL.
module tb;
  import shm_pkg::*;

  typedef struct {
    logic [DIST_W-1:0] min_d;
    logic [COL_W-1:0]  col;
    logic              hit;
  } match_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [7:0]            s_tdata;
  logic                  s_tlast;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [23:0]           m_tdata;
  logic                  m_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sliding_hamming_best_match uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  logic [PATTERN_MAX-1:0] q_pattern;
  logic [LEN_W-1:0]       q_len;
  logic [BASE_W-1:0]      q_base;
  logic [PATTERN_MAX-1:0] win_r;
  logic [COL_W-1:0]       cnt_r;
  logic [DIST_W-1:0]      best_d;
  logic [OFFSET_W-1:0]    best_o;
  logic                   hit_r;

  match_t pending[$];
  match_t want;
  logic   rec_bits[$];
  int     mismatches;
  int     bits_sent;
  int     gap_pct;
  int     stall_pct;

  function automatic logic [LEN_W-1:0] clip_len(input logic [LEN_W-1:0] l);
    if (l == '0) return LEN_W'(1);
    if (l > LEN_W'(PATTERN_MAX)) return LEN_W'(PATTERN_MAX);
    return l;
  endfunction

  task automatic clear_record();
    win_r  = '0;
    cnt_r  = '0;
    best_d = clip_len(q_len);
    best_o = '0;
    hit_r  = 1'b0;
  endtask

  task automatic track_bit(input logic b, input logic last);
    logic [LEN_W-1:0]       l;
    logic [PATTERN_MAX-1:0] w;
    logic [DIST_W-1:0]      d;
    match_t                 m;
    l = clip_len(q_len);
    if (cnt_r < COL_W'(RECORD_MAX)) begin
      if (cnt_r == '0) best_d = l;
      win_r = {b, win_r[PATTERN_MAX-1:1]};
      cnt_r = cnt_r + 1'b1;
      if (cnt_r >= COL_W'(l) && !hit_r) begin
        w = (win_r >> (PATTERN_MAX - l)) ^ q_pattern;
        w = w & ({PATTERN_MAX{1'b1}} >> (PATTERN_MAX - l));
        d = DIST_W'($countones(w));
        if (d == '0) begin
          hit_r  = 1'b1;
          best_d = '0;
          best_o = OFFSET_W'(cnt_r - COL_W'(l));
        end else if (d <= best_d) begin
          best_d = d;
          best_o = OFFSET_W'(cnt_r - COL_W'(l));
        end
      end
    end
    if (last) begin
      if (cnt_r < COL_W'(l)) begin
        m.min_d = l;
        m.col   = COL_W'(q_base);
        m.hit   = 1'b0;
      end else begin
        m.min_d = best_d;
        m.col   = COL_W'(q_base) + COL_W'(best_o);
        m.hit   = hit_r;
      end
      pending.push_back(m);
      clear_record();
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result transaction: dist %0d col %0d hit %0b",
                   m_tdata[6:0], m_tdata[18:7], m_tuser);
        end
      end else begin
        want = pending.pop_front();
        if (m_tdata[6:0] !== want.min_d || m_tdata[18:7] !== want.col ||
            m_tuser !== want.hit) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected dist %0d col %0d hit %0b, got dist %0d col %0d hit %0b",
                     want.min_d, want.col, want.hit, m_tdata[6:0], m_tdata[18:7], m_tuser);
          end
        end
      end
    end
  end

  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 99) < stall_pct) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  task automatic send_bit(input logic b, input logic last);
    if ($urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, b};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    track_bit(b, last);
    bits_sent++;
  endtask

  task automatic send_record();
    for (int i = 0; i < rec_bits.size(); i++) begin
      send_bit(rec_bits[i], i == rec_bits.size() - 1);
    end
  endtask

  task automatic send_value(input logic [63:0] v, input int n);
    rec_bits.delete();
    for (int i = 0; i < n; i++) rec_bits.push_back(v[i]);
    send_record();
  endtask

  task automatic build_record(input int n, input int at, input int flips);
    int l;
    int p;
    l = int'(clip_len(q_len));
    rec_bits.delete();
    for (int i = 0; i < n; i++) rec_bits.push_back(1'($urandom_range(0, 1)));
    if (at >= 0) begin
      for (int j = 0; j < l; j++) rec_bits[at + j] = q_pattern[j];
      for (int k = 0; k < flips; k++) begin
        p = at + $urandom_range(0, l - 1);
        rec_bits[p] = ~rec_bits[p];
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_PATTERN_BITS: q_pattern = v;
      CFG_PATTERN_LEN:  q_len = v[LEN_W-1:0];
      CFG_COLUMN_BASE:  q_base = v[BASE_W-1:0];
      default: ;
    endcase
  endtask

  // The block is drained before the registers change, so no record is in progress.
  task automatic set_config(input logic [63:0] pat, input logic [LEN_W-1:0] len,
                            input logic [BASE_W-1:0] base);
    s_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    write_reg(CFG_PATTERN_BITS, pat);
    write_reg(CFG_PATTERN_LEN, CFG_DATA_W'(len));
    write_reg(CFG_COLUMN_BASE, CFG_DATA_W'(base));
    cfg_valid <= 1'b0;
    clear_record();
  endtask

  task automatic random_record();
    int l;
    int n;
    int r;
    l = int'(clip_len(q_len));
    r = $urandom_range(0, 9);
    if (r == 0) begin
      n = (l > 1) ? $urandom_range(1, l - 1) : 1;
      build_record(n, -1, 0);
    end else if (r == 1) begin
      build_record($urandom_range(1, l + 20), -1, 0);
    end else begin
      n = l + $urandom_range(0, 16);
      build_record(n, $urandom_range(0, n - l), $urandom_range(0, 2));
    end
    send_record();
  endtask

  task automatic test_reset_values();
    send_value(64'd0, 1);
    send_value(64'd1, 1);
    send_value(64'b101, 3);
  endtask

  task automatic test_length_limits();
    set_config('1, 7'd0, 8'd0);
    send_value(64'd0, 2);
    set_config('1, 7'd127, 8'd255);
    send_value(64'd7, 3);
    set_config(64'h2, 7'd2, 8'd100);
    send_value(64'hF, 4);
    send_value(64'b00101, 5);
  endtask

  task automatic test_random_records();
    int               k;
    int               start;
    int               phase_start;
    int               recs;
    logic [63:0]      pat;
    logic [LEN_W-1:0] len;
    logic [7:0]       base;
    k = 0;
    start = bits_sent;
    while (bits_sent - start < 800 || k < 6) begin
      case (k % 6)
        0: len = 7'd64;
        1: len = 7'd127;
        2: len = 7'd0;
        3: len = 7'($urandom_range(1, 8));
        4: len = 7'($urandom_range(1, 64));
        default: len = 7'($urandom_range(1, 16));
      endcase
      case ($urandom_range(0, 5))
        0: pat = '0;
        1: pat = '1;
        default: pat = {$urandom, $urandom};
      endcase
      if (k % 6 == 0) base = 8'd255;
      else if (k % 6 == 1) base = 8'd0;
      else base = 8'($urandom_range(0, 255));
      gap_pct   = (k % 3 == 2) ? 0 : 25;
      stall_pct = (k % 3 == 2) ? 0 : 25;
      set_config(pat, len, base);
      phase_start = bits_sent;
      recs = 0;
      while (bits_sent - phase_start < 120 || recs < 3) begin
        random_record();
        recs++;
      end
      k++;
    end
  endtask

  task automatic test_long_records();
    int l;
    gap_pct   = 25;
    stall_pct = 25;
    set_config({$urandom, $urandom}, 7'($urandom_range(20, 32)), 8'd255);
    l = int'(clip_len(q_len));
    build_record(RECORD_MAX, RECORD_MAX - l, 0);
    send_record();
    build_record(RECORD_MAX + 40, RECORD_MAX + 5, 0);
    send_record();
    build_record(RECORD_MAX + $urandom_range(1, 40), -1, 0);
    send_record();
  endtask

  task automatic test_steady_stream();
    int start;
    gap_pct   = 0;
    stall_pct = 0;
    set_config({$urandom, $urandom}, 7'($urandom_range(1, 12)), 8'($urandom_range(0, 255)));
    start = bits_sent;
    while (bits_sent - start < 100) random_record();
  endtask

  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tlast   <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_PATTERN_BITS;
    cfg_data  <= '0;
    q_pattern = '0;
    q_len     = PATTERN_LEN_RESET;
    q_base    = COLUMN_BASE_RESET;
    clear_record();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_length_limits();
    test_random_records();
    test_long_records();
    test_steady_stream();
    s_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending.size() == 0) begin
      $display("sliding_hamming_best_match test passed");
    end else begin
      $display("sliding_hamming_best_match test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("sliding_hamming_best_match test failed");
    $finish;
  end

endmodule
